// ===== rtl/core/modexp_pkg.sv =====
package modexp_pkg;

  // Operand width of base, exponent, modulus and result.
  localparam int unsigned Width = 32;
  // Reduction step counter width: counts Width steps.
  localparam int unsigned CntW = $clog2(Width);
  // Modulus after reset.
  localparam logic [Width-1:0] ModReset = Width'(10009);

  // Register indexes on the configuration port.
  localparam logic [0:0] RegModulus = 1'b0;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RED_BASE,
    OP_MUL_XY,
    OP_MUL_YY,
    OP_STEP,
    OP_WR_X,
    OP_WR_Y,
    OP_WR_Y_SHIFT,
    OP_SHIFT
  } dp_op_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_BASE,
    S_BASE_STEP,
    S_BASE_WR,
    S_BIT,
    S_MULX,
    S_STEPX,
    S_WRX,
    S_SQ_CHECK,
    S_STEPY,
    S_WRY,
    S_DONE
  } ctrl_state_e;

  // Command from controller to datapath.
  typedef struct packed {
    dp_op_e op;
    logic   publish;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic mod_zero;
    logic exp_zero;
    logic exp_lsb;
    logic exp_rest_zero;
    logic red_last;
  } dp_status_t;

endpackage

// ===== rtl/core/modexp_dp.sv =====
module modexp_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  modexp_pkg::dp_cmd_t              cmd_i,
  output modexp_pkg::dp_status_t           status_o,
  input  logic [modexp_pkg::Width-1:0]     modulus_i,
  input  logic [modexp_pkg::Width-1:0]     base_i,
  input  logic [modexp_pkg::Width-1:0]     exponent_i,
  output logic [modexp_pkg::Width-1:0]     result_o
);

  localparam int unsigned W = modexp_pkg::Width;
  localparam int unsigned CW = modexp_pkg::CntW;

  logic [W-1:0]    x_q, x_d;
  logic [W-1:0]    y_q, y_d;
  logic [W-1:0]    e_q, e_d;
  logic [W-1:0]    r_q, r_d;
  logic [W-1:0]    lo_q, lo_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [W-1:0]    res_q;

  logic [W-1:0]    mul_b;
  logic [2*W-1:0]  prod;
  logic [W:0]      shifted;
  logic [W:0]      diff;
  logic            ge;
  logic            mod_one;

  // One multiplier: x*y or y*y, high half into the remainder, low half into lo.
  assign mul_b = (cmd_i.op == modexp_pkg::OP_MUL_XY) ? x_q : y_q;
  assign prod  = (2*W)'(y_q) * (2*W)'(mul_b);

  // Restoring reduction step: shift in the next low bit, subtract modulus if it fits.
  assign shifted = {r_q, lo_q[W-1]};
  assign diff    = shifted - {1'b0, modulus_i};
  assign ge      = shifted >= {1'b0, modulus_i};
  assign mod_one = modulus_i == W'(1);

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    e_d   = e_q;
    r_d   = r_q;
    lo_d  = lo_q;
    cnt_d = cnt_q;
    case (cmd_i.op)
      modexp_pkg::OP_LOAD: begin
        y_d = base_i;
        e_d = exponent_i;
        x_d = mod_one ? W'(0) : W'(1);
      end
      modexp_pkg::OP_RED_BASE: begin
        r_d   = '0;
        lo_d  = y_q;
        cnt_d = '0;
      end
      modexp_pkg::OP_MUL_XY, modexp_pkg::OP_MUL_YY: begin
        r_d   = prod[2*W-1:W];
        lo_d  = prod[W-1:0];
        cnt_d = '0;
      end
      modexp_pkg::OP_STEP: begin
        r_d   = ge ? diff[W-1:0] : shifted[W-1:0];
        lo_d  = {lo_q[W-2:0], 1'b0};
        cnt_d = cnt_q + CW'(1);
      end
      modexp_pkg::OP_WR_X: begin
        x_d = r_q;
      end
      modexp_pkg::OP_WR_Y: begin
        y_d = r_q;
      end
      modexp_pkg::OP_WR_Y_SHIFT: begin
        y_d = r_q;
        e_d = {1'b0, e_q[W-1:1]};
      end
      modexp_pkg::OP_SHIFT: begin
        e_d = {1'b0, e_q[W-1:1]};
      end
      default: begin
      end
    endcase
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    y_q  <= y_d;
    e_q  <= e_d;
    r_q  <= r_d;
    lo_q <= lo_d;
  end

  // Step counter is control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Result holding register; a zero modulus answers zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      res_q <= (modulus_i == '0) ? W'(0) : x_q;
    end
  end

  assign result_o = res_q;

  assign status_o.mod_zero      = modulus_i == '0;
  assign status_o.exp_zero      = e_q == '0;
  assign status_o.exp_lsb       = e_q[0];
  assign status_o.exp_rest_zero = e_q[W-1:1] == '0;
  assign status_o.red_last      = cnt_q == CW'(W - 1);

endmodule

// ===== rtl/core/modexp_ctrl.sv =====
module modexp_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output modexp_pkg::dp_cmd_t     cmd_o,
  input  modexp_pkg::dp_status_t  status_i
);

  modexp_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  // State and output-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= modexp_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o.op    = modexp_pkg::OP_NONE;
    cmd_o.publish = 1'b0;
    case (state_q)
      modexp_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = modexp_pkg::OP_LOAD;
          state_d  = status_i.mod_zero ? modexp_pkg::S_DONE : modexp_pkg::S_BASE;
        end
      end
      modexp_pkg::S_BASE: begin
        cmd_o.op = modexp_pkg::OP_RED_BASE;
        state_d  = modexp_pkg::S_BASE_STEP;
      end
      modexp_pkg::S_BASE_STEP: begin
        cmd_o.op = modexp_pkg::OP_STEP;
        if (status_i.red_last) begin
          state_d = modexp_pkg::S_BASE_WR;
        end
      end
      modexp_pkg::S_BASE_WR: begin
        cmd_o.op = modexp_pkg::OP_WR_Y;
        state_d  = modexp_pkg::S_BIT;
      end
      modexp_pkg::S_BIT: begin
        if (status_i.exp_zero) begin
          state_d = modexp_pkg::S_DONE;
        end else if (status_i.exp_lsb) begin
          state_d = modexp_pkg::S_MULX;
        end else begin
          state_d = modexp_pkg::S_SQ_CHECK;
        end
      end
      modexp_pkg::S_MULX: begin
        cmd_o.op = modexp_pkg::OP_MUL_XY;
        state_d  = modexp_pkg::S_STEPX;
      end
      modexp_pkg::S_STEPX: begin
        cmd_o.op = modexp_pkg::OP_STEP;
        if (status_i.red_last) begin
          state_d = modexp_pkg::S_WRX;
        end
      end
      modexp_pkg::S_WRX: begin
        cmd_o.op = modexp_pkg::OP_WR_X;
        state_d  = modexp_pkg::S_SQ_CHECK;
      end
      // The square is skipped once no further exponent bit is set.
      modexp_pkg::S_SQ_CHECK: begin
        if (status_i.exp_rest_zero) begin
          cmd_o.op = modexp_pkg::OP_SHIFT;
          state_d  = modexp_pkg::S_BIT;
        end else begin
          cmd_o.op = modexp_pkg::OP_MUL_YY;
          state_d  = modexp_pkg::S_STEPY;
        end
      end
      modexp_pkg::S_STEPY: begin
        cmd_o.op = modexp_pkg::OP_STEP;
        if (status_i.red_last) begin
          state_d = modexp_pkg::S_WRY;
        end
      end
      modexp_pkg::S_WRY: begin
        cmd_o.op = modexp_pkg::OP_WR_Y_SHIFT;
        state_d  = modexp_pkg::S_BIT;
      end
      // Hand the result over once the output register is free.
      modexp_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = modexp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = modexp_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/modular_exponentiation.sv =====
// Modular exponentiation: power_mod = base ** exponent mod modulus.
// Input stream (s_axis): one item carries base and exponent in tdata.
// Output stream (m_axis): one item per input item carries power_mod.
// Configuration: APB-style port, register 0 at byte address 0 holds the
// modulus; write it only while the block is idle. A zero modulus gives 0.
// The block works on one item at a time with one 32 x 32 multiplier and a
// restoring reduction unit that retires one remainder bit per cycle; each
// modular multiply is a multiply, 32 reduction steps and a write back.
// Order of work after an item is accepted: the base is reduced first, then
// each exponent bit up to its highest set bit is checked; a one bit costs a
// modular multiply and every bit below the highest a modular square, while
// at the highest set bit the square is skipped. Then the result is published.
// Exponent zero only reduces the base; a zero modulus goes straight to
// publishing the result.
// A new item is accepted as soon as the previous result sits in the output
// register; if the receiver stalls, that result holds and the next result
// waits inside the block until the output register frees.
// Reset clears m_axis_tvalid, returns the block to idle and sets the modulus
// to 10009; the output data register itself is not reset.
module modular_exponentiation (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] base, [63:32] exponent
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] power_mod
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned W = modexp_pkg::Width;

  logic [W-1:0]            modulus_q;
  logic                    reg_write;
  modexp_pkg::dp_cmd_t     cmd;
  modexp_pkg::dp_status_t  status;

  // Modulus register.
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready && (paddr[2] == modexp_pkg::RegModulus);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= modexp_pkg::ModReset;
    end else if (reg_write) begin
      modulus_q <= pwdata[W-1:0];
    end
  end

  assign prdata = (paddr[2] == modexp_pkg::RegModulus) ? modulus_q : 32'd0;

  modexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  modexp_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .modulus_i  (modulus_q),
    .base_i     (s_axis_tdata[W-1:0]),
    .exponent_i (s_axis_tdata[2*W-1:W]),
    .result_o   (m_axis_tdata)
  );

endmodule

// ===== tb/sv/modular_exponentiation_test.sv =====
`timescale 1ns / 100ps

module modular_exponentiation_test;

  localparam int unsigned      Width      = modexp_pkg::Width;
  localparam logic [0:0]       RegModulus = modexp_pkg::RegModulus;
  localparam logic [Width-1:0] ModReset   = modexp_pkg::ModReset;

  // Byte addresses on the configuration port.
  localparam logic [2:0] ModulusAddr = {RegModulus, 2'b00};
  localparam logic [2:0] UnusedAddr  = 3'd4;

  localparam int NumDirected = 24;
  localparam int NumPhases   = 12;
  localparam int PhaseItems  = 100;

  // One directed item: the modulus it runs under, whether a write to the
  // unused register precedes it, the operands and, where obvious, the answer.
  typedef struct packed {
    logic [Width-1:0] modulus;
    logic             stray;
    logic [Width-1:0] base;
    logic [Width-1:0] expo;
    logic             known;
    logic [Width-1:0] power;
  } dir_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [63:0]      s_axis_tdata;   // [31:0] base, [63:32] exponent
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [31:0]      m_axis_tdata;   // [31:0] power_mod
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  logic [Width-1:0] modulus_q = ModReset;
  logic [Width-1:0] power_q[$];
  int               error_count = 0;
  logic             steady = 1'b0;

  dir_row_t dir_rows [NumDirected] = '{
    // Reset modulus.
    '{32'd10009, 1'b0, 32'd0, 32'd0, 1'b1, 32'd1},
    '{32'd10009, 1'b0, 32'd2, 32'd10, 1'b1, 32'd1024},
    '{32'd10009, 1'b0, 32'd10009, 32'd5, 1'b1, 32'd0},
    '{32'd10009, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'd0},
    '{32'd10009, 1'b0, 32'd0, 32'd7, 1'b1, 32'd0},
    // A write to the unused register leaves the modulus alone.
    '{32'd10009, 1'b1, 32'd3, 32'd0, 1'b1, 32'd1},
    // Modulus one: every result is zero, exponent zero too.
    '{32'd1, 1'b0, 32'd0, 32'd0, 1'b1, 32'd0},
    '{32'd1, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'd0},
    // Largest modulus: base m-1 behaves as minus one.
    '{32'hFFFFFFFF, 1'b0, 32'hFFFFFFFE, 32'd2, 1'b1, 32'd1},
    '{32'hFFFFFFFF, 1'b0, 32'hFFFFFFFE, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFE},
    '{32'hFFFFFFFF, 1'b0, 32'hFFFFFFFF, 32'd3, 1'b1, 32'd0},
    '{32'hFFFFFFFF, 1'b0, 32'd0, 32'd0, 1'b1, 32'd1},
    '{32'hFFFFFFFF, 1'b0, 32'h12345678, 32'h80000000, 1'b0, 32'd0},
    '{32'hFFFFFFFF, 1'b0, 32'hDEADBEEF, 32'hAAAAAAAA, 1'b0, 32'd0},
    // Zero modulus answers zero.
    '{32'd0, 1'b0, 32'd5, 32'd3, 1'b1, 32'd0},
    '{32'd0, 1'b0, 32'd0, 32'd0, 1'b1, 32'd0},
    '{32'd0, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'd0},
    // Smallest useful modulus, then modulus 7.
    '{32'd2, 1'b0, 32'd3, 32'd0, 1'b1, 32'd1},
    '{32'd2, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'd1},
    '{32'd2, 1'b0, 32'd4, 32'd1, 1'b1, 32'd0},
    '{32'd7, 1'b0, 32'd3, 32'd6, 1'b1, 32'd1},
    '{32'd7, 1'b0, 32'h55555555, 32'h55555555, 1'b0, 32'd0},
    // Power of two modulus.
    '{32'h80000000, 1'b0, 32'd2, 32'd31, 1'b1, 32'd0},
    '{32'h80000000, 1'b0, 32'd2, 32'd30, 1'b1, 32'h40000000}
  };

  modular_exponentiation dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Right-to-left square and multiply; products at double width never wrap.
  function automatic logic [Width-1:0] modexp_predict(logic [Width-1:0] base,
                                                      logic [Width-1:0] expo,
                                                      logic [Width-1:0] m);
    logic [2*Width-1:0] m_wide;
    logic [2*Width-1:0] acc;
    logic [2*Width-1:0] run;
    m_wide = {{Width{1'b0}}, m};
    if (m == '0) begin
      return '0;
    end
    acc = 1 % m_wide;
    run = {{Width{1'b0}}, base} % m_wide;
    for (int i = 0; i < Width; i++) begin
      if (expo[i]) begin
        acc = (acc * run) % m_wide;
      end
      run = (run * run) % m_wide;
    end
    return acc[Width-1:0];
  endfunction

  // Idle with a chance of about 35 in a hundred, except during the steady phase.
  function automatic logic idle_now();
    return !steady && ($urandom_range(99) < 35);
  endfunction

  task automatic check_fail(input string what, input logic [31:0] got,
                            input logic [31:0] want);
    $display("mismatch: %s got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // One APB transfer: setup phase, access phase until pready, then back at rest.
  task automatic apb_xfer(input logic wr, input logic [2:0] addr,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    if (wr && addr == ModulusAddr) begin
      modulus_q = wdata;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop sending and let every pending result come out.
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (power_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_modulus(input logic [Width-1:0] value);
    logic [31:0] rd;
    apb_xfer(1'b1, ModulusAddr, value, rd);
    apb_xfer(1'b0, ModulusAddr, '0, rd);
    if (rd !== modulus_q) check_fail("modulus readback", rd, modulus_q);
  endtask

  task automatic write_unused();
    logic [31:0] rd;
    apb_xfer(1'b1, UnusedAddr, $urandom, rd);
  endtask

  // Offer one item, wait for its acceptance and record the expected power.
  task automatic send_item(input logic [Width-1:0] base, input logic [Width-1:0] expo,
                           input logic known, input logic [Width-1:0] power);
    logic [Width-1:0] want;
    while (idle_now()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {expo, base};
    do @(posedge clk_i); while (!s_axis_tready);
    want = known ? power : modexp_predict(base, expo, modulus_q);
    power_q = {power_q, want};
  endtask

  // Result side: compare each accepted item, then pick the next ready.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (power_q.size() == 0) begin
          check_fail("unexpected power_mod", m_axis_tdata, '0);
        end else if (m_axis_tdata !== power_q[0]) begin
          check_fail("power_mod", m_axis_tdata, power_q[0]);
          void'(power_q.pop_front());
        end else begin
          void'(power_q.pop_front());
        end
      end
      m_axis_tready <= !idle_now();
    end
  end

  // Stimulus: directed table, then phases of random items per modulus.
  initial begin
    logic [Width-1:0] m;
    logic [Width-1:0] base;
    logic [Width-1:0] expo;
    logic [31:0]      rd;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The modulus must read back as its reset value.
    apb_xfer(1'b0, ModulusAddr, '0, rd);
    if (rd !== ModReset) check_fail("modulus after reset", rd, ModReset);

    for (int i = 0; i < NumDirected; i++) begin
      if (dir_rows[i].modulus != modulus_q || dir_rows[i].stray) begin
        settle_idle();
        if (dir_rows[i].modulus != modulus_q) write_modulus(dir_rows[i].modulus);
        if (dir_rows[i].stray) write_unused();
      end
      send_item(dir_rows[i].base, dir_rows[i].expo, dir_rows[i].known,
                dir_rows[i].power);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: m = '1;
        1: m = 1;
        2: m = '0;
        default: begin
          case ($urandom_range(9))
            0:       m = 1;
            1:       m = '1;
            2:       m = '0;
            3, 4, 5: m = $urandom_range(1000, 2);
            default: m = $urandom;
          endcase
        end
      endcase
      settle_idle();
      steady = 1'b0;
      write_modulus(m);
      if (ph % 4 == 3) write_unused();
      steady = (ph == 5);
      for (int k = 0; k < PhaseItems; k++) begin
        case ($urandom_range(3))
          1:       base = $urandom_range(15);
          2:       base = m - 1 + $urandom_range(2);
          default: base = $urandom;
        endcase
        // Mostly short exponents keep the run short; a tenth use all bits.
        if ($urandom_range(9) == 0) begin
          expo = $urandom;
        end else begin
          expo = 32'($urandom) >> (32 - $urandom_range(6));
        end
        send_item(base, expo, 1'b0, '0);
      end
    end

    settle_idle();
    steady = 1'b0;
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("modular_exponentiation_test OK");
    end else begin
      $display("modular_exponentiation_test NOT OK");
    end
    $finish;
  end

  // Run limit, several times the slowest correct run.
  initial begin
    #(64'd200_000_000);
    $display("modular_exponentiation_test NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/modexp_pkg.sv
rtl/core/modexp_dp.sv
rtl/core/modexp_ctrl.sv
rtl/core/modular_exponentiation.sv
tb/sv/modular_exponentiation_test.sv
